// File: hw/rtl/sv39ptm_pkg.sv
// Shared types, codes and sizes of the Sv39 page table mapper.
package sv39ptm_pkg;

	// Table store geometry
	localparam int TABLE_PAGES       = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int VPN_W             = $clog2(ENTRIES_PER_TABLE);
	localparam int PAGE_W            = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int NFT_W             = $clog2(TABLE_PAGES + 1);
	localparam int ADDR_W            = PAGE_W + VPN_W;
	localparam int MEM_DEPTH         = TABLE_PAGES * ENTRIES_PER_TABLE;

	// Field widths
	localparam int PPN_W   = 44;
	localparam int VPAGE_W = 27;
	localparam int VA_W    = 39;
	localparam int PTE_W   = 54;
	localparam int FLAG_W  = 10;
	localparam int PERM_W  = 8;

	// Commands
	localparam logic [1:0] CMD_MAP    = 2'd0;
	localparam logic [1:0] CMD_UNMAP  = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RANGE     = 3'd1;
	localparam logic [2:0] ST_NOTABLE   = 3'd2;
	localparam logic [2:0] ST_NOTMAPPED = 3'd3;
	localparam logic [2:0] ST_NOTLEAF   = 3'd4;

	// Configuration register indexes
	localparam int         CFG_IDX_W      = 1;
	localparam logic [0:0] CFG_TABLE_BASE = 1'd0;
	localparam logic [0:0] CFG_VA_LIMIT   = 1'd1;

	// Walk levels
	localparam logic [1:0] LVL_TOP  = 2'd2;
	localparam logic [1:0] LVL_MID  = 2'd1;
	localparam logic [1:0] LVL_LEAF = 2'd0;

	localparam logic [VA_W-1:0] VA_LIMIT_RST = VA_W'(64'd1 << 38);

	typedef struct packed {
		logic [1:0]         cmd;
		logic [VPAGE_W-1:0] vpage;
		logic [PPN_W-1:0]   ppage;
		logic [PERM_W-1:0]  perm;
		logic               alloc_tables;
		logic               free_page;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [PTE_W-1:0] entry;
		logic             free_valid;
		logic [PPN_W-1:0] free_ppage;
	} out_item_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_DONE
	} state_t;

endpackage

// File: hw/rtl/sv39_page_table_mapper.sv
// Sv39 page table mapper: sequencer, table store and result register.
//
// Usage: one transaction on the input channel (in_valid, in_stall, in_data)
// maps, unmaps or looks up one virtual page; exactly one transaction follows
// on the output channel (out_valid, out_stall, out_data) with the status, the
// leaf entry and a free request for the host. The table store (TABLE_PAGES
// pages of 512 entries) is a single-port style memory with registered read.
// Walk: each level walked passes a READ state and an EVAL state through
// that memory, and after the last EVAL the DONE state loads the result
// register; a range error or an unused command goes from the top READ to DONE.
// A new transaction is accepted in the cycle after the result is loaded; the
// block takes no new transaction while one is being walked or waits in DONE.
// Reset: arst_n clears the control state, then a clearing pass zeroes all
// TABLE_PAGES*512 entries of the table store (8192 at the default size), one
// entry a cycle; in_stall stays high during that pass. Configuration writes
// (cfg_valid, cfg_ready, cfg_index, cfg_data) are always taken.
// Stall: a pending result holds in the output register while out_stall is
// high; the next transaction may be accepted and walked meanwhile, and the
// sequencer waits to hand over its result until the register frees up.
module sv39_page_table_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  sv39ptm_pkg::in_item_t             in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output sv39ptm_pkg::out_item_t            out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sv39ptm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sv39ptm_pkg::PPN_W-1:0]     cfg_data
);
	import sv39ptm_pkg::*;

	// Control and config registers
	state_t              state_q, state_nxt;
	in_item_t            req_q;
	out_item_t           res_q, out_q;
	logic                out_valid_q;
	logic [1:0]          level_q;
	logic [PAGE_W-1:0]   page_q;
	logic [NFT_W-1:0]    nft_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [PPN_W-1:0]    base_q;
	logic [VA_W-1:0]     limit_q;

	// Table store
	logic [PTE_W-1:0]    mem [MEM_DEPTH];
	logic [PTE_W-1:0]    rdata_q;

	// Decode of the current step
	logic                in_acc;
	logic                out_take;
	logic                res_load;
	logic [VPN_W-1:0]    vpn;
	logic [ADDR_W-1:0]   addr;
	logic                range_bad;
	logic [VPAGE_W:0]    vpage_inc;
	logic                alloc_en;
	logic [PPN_W-1:0]    ptr_idx;
	logic                ptr_ok;
	logic                store_full;
	logic [PTE_W-1:0]    table_pte;
	logic [PTE_W-1:0]    leaf_pte;
	logic                e_valid;

	// Step decisions
	logic                rd_finish;    // READ ends the transaction
	logic                ev_descend;   // EVAL moves down one level
	logic                ev_alloc;     // EVAL takes a fresh table page
	logic                mem_we;
	logic [PTE_W-1:0]    mem_wdata;
	logic [ADDR_W-1:0]   mem_waddr;
	out_item_t           res_nxt;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_take  = out_valid_q && !out_stall;
	assign res_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Slot address of the current level
	always_comb begin
		case (level_q)
			LVL_TOP:  vpn = req_q.vpage[3*VPN_W-1:2*VPN_W];
			LVL_MID:  vpn = req_q.vpage[2*VPN_W-1:VPN_W];
			default:  vpn = req_q.vpage[VPN_W-1:0];
		endcase
	end
	assign addr = {page_q, vpn};

	// Page must end at or below the limit
	assign vpage_inc = {1'b0, req_q.vpage} + (VPAGE_W+1)'(1);
	assign range_bad = {vpage_inc, 12'b0} > {1'b0, limit_q};

	assign alloc_en   = (req_q.cmd == CMD_MAP) ||
		((req_q.cmd == CMD_LOOKUP) && req_q.alloc_tables);
	assign e_valid    = rdata_q[0];
	assign ptr_idx    = rdata_q[PTE_W-1:FLAG_W] - base_q;
	assign ptr_ok     = ptr_idx < PPN_W'(nft_q);
	assign store_full = (nft_q == NFT_W'(TABLE_PAGES));
	assign table_pte  = {base_q + PPN_W'(nft_q), FLAG_W'(1)};
	assign leaf_pte   = {req_q.ppage, 2'b00, req_q.perm | PERM_W'(1)};

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) state_nxt = S_READ;
			end
			S_READ: begin
				state_nxt = rd_finish ? S_DONE : S_EVAL;
			end
			S_EVAL: begin
				state_nxt = ev_descend ? S_READ : S_DONE;
			end
			S_DONE: begin
				if (res_load) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Step outputs: memory write, result fields and walk decisions
	always_comb begin
		rd_finish  = 1'b0;
		ev_descend = 1'b0;
		ev_alloc   = 1'b0;
		mem_we     = 1'b0;
		mem_wdata  = '0;
		mem_waddr  = addr;
		res_nxt    = res_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_READ: begin
				if (level_q == LVL_TOP) begin
					if (req_q.cmd != CMD_MAP && req_q.cmd != CMD_UNMAP &&
						req_q.cmd != CMD_LOOKUP) begin
						rd_finish = 1'b1;
					end else if (range_bad) begin
						rd_finish      = 1'b1;
						res_nxt.status = ST_RANGE;
					end
				end
			end
			S_EVAL: begin
				if (level_q != LVL_LEAF) begin
					if (e_valid) begin
						if (ptr_ok) ev_descend = 1'b1;
						else res_nxt.status = ST_NOTABLE;
					end else if (!alloc_en) begin
						res_nxt.status = ST_NOTMAPPED;
					end else if (store_full) begin
						res_nxt.status = ST_NOTABLE;
					end else begin
						ev_descend = 1'b1;
						ev_alloc   = 1'b1;
						mem_we     = 1'b1;
						mem_wdata  = table_pte;
					end
				end else begin
					case (req_q.cmd)
						CMD_MAP: begin
							mem_we        = 1'b1;
							mem_wdata     = leaf_pte;
							res_nxt.entry = leaf_pte;
						end
						CMD_UNMAP: begin
							res_nxt.entry = rdata_q;
							if (!e_valid) begin
								res_nxt.status = ST_NOTMAPPED;
							end else if (rdata_q[FLAG_W-1:0] == FLAG_W'(1)) begin
								res_nxt.status = ST_NOTLEAF;
							end else begin
								mem_we = 1'b1;
								if (req_q.free_page) begin
									res_nxt.free_valid = 1'b1;
									res_nxt.free_ppage = rdata_q[PTE_W-1:FLAG_W];
								end
							end
						end
						default: res_nxt.entry = rdata_q;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			nft_q   <= NFT_W'(1);
			level_q <= LVL_TOP;
			page_q  <= '0;
			base_q  <= '0;
			limit_q <= VA_LIMIT_RST;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (in_acc) begin
				level_q <= LVL_TOP;
				page_q  <= '0;
			end
			if (ev_descend) begin
				level_q <= level_q - 2'd1;
				page_q  <= ev_alloc ? nft_q[PAGE_W-1:0] : ptr_idx[PAGE_W-1:0];
			end
			if (ev_alloc) nft_q <= nft_q + NFT_W'(1);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TABLE_BASE: base_q  <= cfg_data;
					CFG_VA_LIMIT:   limit_q <= cfg_data[VA_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Output register: hold while stalled, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= in_data;
			res_q <= '0;
		end else begin
			res_q <= res_nxt;
		end
		if (res_load) out_q <= res_q;
	end

	// Table store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (state_q == S_READ) rdata_q <= mem[addr];
	end

	// Allocation counter stays within the store and never hands out the root
	a_nft_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nft_q >= NFT_W'(1)) && (nft_q <= NFT_W'(TABLE_PAGES)))
		else $error("table page counter out of range");

	// A table page is taken only with a table entry written, one page each time
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && level_q != LVL_LEAF && mem_we) |=>
		(nft_q == $past(nft_q) + NFT_W'(1)))
		else $error("table allocation without counter advance");

	// A result appears only as handed over by the sequencer
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside of completion");

	// A free request only comes with a successful unmap of a valid leaf
	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.free_valid) |->
		(out_q.status == ST_OK && out_q.entry[0]))
		else $error("free request on failed unmap");

endmodule

// File: bench/sv39_page_table_mapper_test.sv
// Self-checking testbench of the Sv39 page table mapper: driver, monitor and table walk predictor.
`timescale 1ns / 100ps

module sv39_page_table_mapper_test;
	import sv39ptm_pkg::*;

	// Code 3 of the command field has no meaning; the block must ignore it.
	localparam logic [1:0]        CMD_UNUSED   = 2'd3;
	localparam logic [FLAG_W-1:0] FLAGS_V_ONLY = 10'd1;
	localparam int                SETTLE_CYCLES = 16;

	typedef struct {
		in_item_t req;
		bit       drain_first;
	} pending_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PPN_W-1:0]     cfg_data = '0;

	// Requests waiting for the driver, and results the block still owes.
	pending_req_t pending_requests[$];
	out_item_t    expected_results[$];

	// Idle percentages of the two sides, set per phase.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned mismatch_count = 0;
	int unsigned accepted_count = 0;
	int unsigned checked_count = 0;
	int unsigned freed_count = 0;
	int unsigned phase_count = 0;
	int unsigned status_hits[0:7];

	// Shadow of the table store, the bump counter and the two registers.
	logic [PTE_W-1:0] shadow_tables[MEM_DEPTH];
	int unsigned      shadow_next_table;
	logic [PPN_W-1:0] shadow_base_ppn;
	logic [VA_W-1:0]  shadow_va_limit;

	// Three regions of the upper index, two middle indexes each: six hot leaf tables.
	int unsigned hot_vpn2[3];
	int unsigned hot_vpn1[3][2];

	sv39_page_table_mapper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Hard stop: far beyond the slowest legal run, clearing pass included.
	initial begin
		#5_000_000;
		$display("sv39_page_table_mapper test failed");
		$finish;
	end

	function automatic int unsigned slot_of_level(int unsigned page, logic [VPAGE_W-1:0] vp,
			int lvl);
		return page * ENTRIES_PER_TABLE + int'((vp >> (VPN_W * lvl)) & (ENTRIES_PER_TABLE - 1));
	endfunction

	// Walk the shadow tables down to the leaf slot, growing missing tables if asked.
	function automatic logic [2:0] walk_to_leaf(input logic [VPAGE_W-1:0] vp, input bit grow,
			output int unsigned leaf_slot);
		int unsigned      page;
		int unsigned      s;
		logic [PTE_W-1:0] e;
		logic [PPN_W-1:0] idx;
		logic [PPN_W-1:0] ppn;
		page = 0;
		leaf_slot = 0;
		for (int lvl = 2; lvl > 0; lvl--) begin
			s = slot_of_level(page, vp, lvl);
			e = shadow_tables[s];
			if (e[0]) begin
				// Translate the pointer back to a table page; refuse anything not handed out.
				idx = e[PTE_W-1:FLAG_W] - shadow_base_ppn;
				if (idx >= shadow_next_table || idx >= TABLE_PAGES)
					return ST_NOTABLE;
				page = int'(idx);
			end else begin
				if (!grow)
					return ST_NOTMAPPED;
				if (shadow_next_table >= TABLE_PAGES)
					return ST_NOTABLE;
				page = shadow_next_table;
				shadow_next_table++;
				ppn = shadow_base_ppn + PPN_W'(page);
				shadow_tables[s] = {ppn, FLAGS_V_ONLY};
			end
		end
		leaf_slot = slot_of_level(page, vp, 0);
		return ST_OK;
	endfunction

	// Apply one request to the shadow state and return the result it must produce.
	function automatic out_item_t predict_mapping(in_item_t req);
		out_item_t        r;
		int unsigned      slot;
		logic [PTE_W-1:0] e;
		logic [VA_W:0]    end_va;
		r = '0;
		end_va = ({1'b0, VA_W'(req.vpage)} + 1'b1) << 12;
		if (req.cmd == CMD_MAP || req.cmd == CMD_UNMAP || req.cmd == CMD_LOOKUP) begin
			if (end_va > {1'b0, shadow_va_limit}) begin
				r.status = ST_RANGE;
			end else if (req.cmd == CMD_MAP) begin
				r.status = walk_to_leaf(req.vpage, 1'b1, slot);
				if (r.status == ST_OK) begin
					r.entry = {req.ppage, 2'b00, req.perm | 8'h01};
					shadow_tables[slot] = r.entry;
				end
			end else if (req.cmd == CMD_UNMAP) begin
				r.status = walk_to_leaf(req.vpage, 1'b0, slot);
				if (r.status == ST_OK) begin
					e = shadow_tables[slot];
					r.entry = e;
					if (!e[0]) begin
						r.status = ST_NOTMAPPED;
					end else if (e[FLAG_W-1:0] == FLAGS_V_ONLY) begin
						r.status = ST_NOTLEAF;
					end else begin
						if (req.free_page) begin
							r.free_valid = 1'b1;
							r.free_ppage = e[PTE_W-1:FLAG_W];
						end
						shadow_tables[slot] = '0;
					end
				end
			end else begin
				r.status = walk_to_leaf(req.vpage, req.alloc_tables, slot);
				if (r.status == ST_OK)
					r.entry = shadow_tables[slot];
			end
		end
		return r;
	endfunction

	// Driver: on acceptance predict the result, then present the next request or idle.
	always @(posedge clk) begin
		bit send;
		if (in_valid && !in_stall) begin
			expected_results.push_back(predict_mapping(in_data));
			accepted_count++;
		end
		if (!in_valid || !in_stall) begin
			send = pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
			// Hold off a marked request until the block has handed back everything.
			if (send && pending_requests[0].drain_first && expected_results.size() != 0)
				send = 1'b0;
			if (send) begin
				in_data <= pending_requests[0].req;
				void'(pending_requests.pop_front());
			end
			in_valid <= send;
		end
	end

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %0s at %0t: expected 0x%0h, got 0x%0h", what, $realtime, want, got);
	endtask

	// Monitor: compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", '0, 64'(out_data.status));
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				if (out_data.status !== want.status)
					report_mismatch("status", 64'(want.status), 64'(out_data.status));
				if (out_data.entry !== want.entry)
					report_mismatch("entry", 64'(want.entry), 64'(out_data.entry));
				if (out_data.free_valid !== want.free_valid)
					report_mismatch("free_valid", 64'(want.free_valid), 64'(out_data.free_valid));
				if (out_data.free_ppage !== want.free_ppage)
					report_mismatch("free_ppage", 64'(want.free_ppage), 64'(out_data.free_ppage));
				if (want.status <= ST_NOTLEAF)
					status_hits[want.status]++;
				if (want.free_valid)
					freed_count++;
			end
		end
		out_stall <= $urandom_range(0, 99) < recv_stall_pct;
	end

	function automatic logic [VPAGE_W-1:0] hot_page(int p, logic [VPN_W-1:0] vpn0);
		return {VPN_W'(hot_vpn2[p / 2]), VPN_W'(hot_vpn1[p / 2][p % 2]), vpn0};
	endfunction

	function automatic logic [VPAGE_W-1:0] page_at(int unsigned v2, int unsigned v1,
			int unsigned v0);
		return {VPN_W'(v2), VPN_W'(v1), VPN_W'(v0)};
	endfunction

	task automatic queue_request(logic [1:0] cmd, logic [VPAGE_W-1:0] vp, logic [PPN_W-1:0] pp,
			logic [PERM_W-1:0] perm, bit alloc, bit free_it, bit drain = 1'b0);
		pending_req_t pr;
		pr.req.cmd = cmd;
		pr.req.vpage = vp;
		pr.req.ppage = pp;
		pr.req.perm = perm;
		pr.req.alloc_tables = alloc;
		pr.req.free_page = free_it;
		pr.drain_first = drain;
		pending_requests.push_back(pr);
	endtask

	// Mostly well-formed traffic on the hot leaf tables, the rest random noise.
	function automatic in_item_t random_request();
		in_item_t         req;
		int unsigned      pick;
		logic [VPN_W-1:0] vpn0;
		req.ppage = PPN_W'({$urandom, $urandom});
		req.perm = ($urandom_range(0, 7) == 0) ? '0 : PERM_W'($urandom);
		req.alloc_tables = 1'($urandom);
		req.free_page = 1'($urandom);
		if ($urandom_range(0, 99) < 75) begin
			vpn0 = ($urandom_range(0, 3) == 0) ? VPN_W'($urandom) : VPN_W'($urandom_range(0, 15));
			req.vpage = hot_page($urandom_range(0, 5), vpn0);
			pick = $urandom_range(0, 9);
			req.cmd = (pick < 4) ? CMD_MAP : (pick < 7) ? CMD_LOOKUP : CMD_UNMAP;
		end else begin
			req.vpage = VPAGE_W'($urandom);
			req.cmd = 2'($urandom);
		end
		return req;
	endfunction

	// Wait until nothing is queued or owed, then let the block settle.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [PPN_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_TABLE_BASE)
			shadow_base_ppn = value;
		else
			shadow_va_limit = value[VA_W-1:0];
	endtask

	task automatic run_random(int unsigned count, int unsigned drain_every);
		pending_req_t pr;
		phase_count++;
		for (int unsigned i = 0; i < count; i++) begin
			pr.req = random_request();
			pr.drain_first = drain_every != 0 && (i % drain_every) == drain_every - 1;
			pending_requests.push_back(pr);
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < MEM_DEPTH; i++)
			shadow_tables[i] = '0;
		for (int i = 0; i < 8; i++)
			status_hits[i] = 0;
		shadow_next_table = 1;
		shadow_base_ppn = '0;
		shadow_va_limit = VA_LIMIT_RST;

		hot_vpn2[0] = 0;
		hot_vpn2[1] = $urandom_range(1, 99);
		hot_vpn2[2] = $urandom_range(100, 199);
		hot_vpn1[0][0] = 0;
		hot_vpn1[0][1] = 1;
		for (int i = 1; i < 3; i++) begin
			hot_vpn1[i][0] = $urandom_range(0, 255);
			hot_vpn1[i][1] = $urandom_range(256, 511);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings of both registers.
		write_register(CFG_TABLE_BASE, '0);
		write_register(CFG_VA_LIMIT, PPN_W'(VA_LIMIT_RST));
		phase_count++;
		send_idle_pct = 15;
		recv_stall_pct = 82;
		queue_request(CMD_UNUSED, VPAGE_W'($urandom), PPN_W'({$urandom, $urandom}), 8'hff, 1, 1);
		// Empty root: lookup without growth and unmap both find nothing.
		queue_request(CMD_LOOKUP, hot_page(0, 5), '0, '0, 0, 0);
		queue_request(CMD_UNMAP, hot_page(0, 5), '0, '0, 0, 1);
		// Zero permissions leave V alone: such an entry cannot be unmapped.
		queue_request(CMD_MAP, '0, '0, '0, 0, 0);
		queue_request(CMD_UNMAP, '0, '0, '0, 0, 1);
		queue_request(CMD_LOOKUP, '0, '0, '0, 0, 0, 1);
		// Empty slot in a present leaf table.
		queue_request(CMD_LOOKUP, page_at(0, 0, 1), '0, '0, 0, 0);
		queue_request(CMD_UNMAP, page_at(0, 0, 1), '0, '0, 0, 1);
		// Map, remap, unmap with free, then a second unmap of the cleared slot.
		queue_request(CMD_MAP, page_at(0, 0, 511), '1, '1, 0, 0);
		queue_request(CMD_MAP, page_at(0, 0, 511), PPN_W'({$urandom, $urandom}), 8'h0e, 0, 0);
		queue_request(CMD_UNMAP, page_at(0, 0, 511), '0, '0, 0, 1);
		queue_request(CMD_UNMAP, page_at(0, 0, 511), '0, '0, 0, 1);
		// Missing middle table: refused without growth, grown with it.
		queue_request(CMD_LOOKUP, hot_page(1, 3), '0, '0, 0, 0);
		queue_request(CMD_LOOKUP, hot_page(1, 3), '0, '0, 1, 0);
		queue_request(CMD_MAP, hot_page(2, 0), PPN_W'({$urandom, $urandom}), 8'h06, 0, 0);
		queue_request(CMD_MAP, hot_page(3, 9), PPN_W'({$urandom, $urandom}), 8'h1a, 0, 0);
		queue_request(CMD_MAP, hot_page(4, 2), PPN_W'({$urandom, $urandom}), 8'h0a, 0, 0);
		queue_request(CMD_LOOKUP, hot_page(5, 7), '0, '0, 1, 0);
		// Range edges: just past the limit, all ones, and the last page inside.
		queue_request(CMD_MAP, VPAGE_W'(1) << 26, '1, '1, 0, 0);
		queue_request(CMD_LOOKUP, '1, '0, '0, 1, 0);
		queue_request(CMD_MAP, (VPAGE_W'(1) << 26) - 1'b1, PPN_W'({$urandom, $urandom}), 8'hce,
			0, 0);
		// Use up the store, ending with a failure after a grown upper table.
		queue_request(CMD_MAP, page_at(254, 0, 0), PPN_W'({$urandom, $urandom}), 8'h02, 0, 0);
		queue_request(CMD_MAP, page_at(254, 7, 3), PPN_W'({$urandom, $urandom}), 8'h04, 0, 0);
		queue_request(CMD_MAP, page_at(253, 0, 0), PPN_W'({$urandom, $urandom}), 8'h02, 0, 0);
		queue_request(CMD_LOOKUP, page_at(253, 5, 0), '0, '0, 1, 0);
		queue_request(CMD_UNMAP, page_at(253, 5, 0), '0, '0, 0, 1);
		queue_request(CMD_MAP, page_at(252, 0, 0), PPN_W'({$urandom, $urandom}), 8'h02, 0, 0);
		wait_drained();

		// Slow receiver: widest address limit, then the top table base.
		send_idle_pct = 15;
		recv_stall_pct = 82;
		write_register(CFG_VA_LIMIT, '1);
		run_random(350, 40);
		write_register(CFG_TABLE_BASE, '1);
		run_random(150, 0);

		// Slow sender: table base back at zero, random address limit.
		send_idle_pct = 82;
		recv_stall_pct = 15;
		write_register(CFG_TABLE_BASE, '0);
		write_register(CFG_VA_LIMIT, PPN_W'({$urandom, $urandom}) | (PPN_W'(1) << 36));
		run_random(350, 0);

		// No idling: zero limit rejects every map, unmap and lookup, then the reset limit again.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_register(CFG_VA_LIMIT, '0);
		run_random(30, 0);
		write_register(CFG_VA_LIMIT, PPN_W'(VA_LIMIT_RST));
		run_random(150, 0);

		if (expected_results.size() != 0)
			mismatch_count += expected_results.size();

		$display("Ran %0d transactions in %0d phases, %0d results checked, %0d pages freed.",
			accepted_count, phase_count, checked_count, freed_count);
		$display("Status mix: ok %0d, range %0d, no table %0d, not mapped %0d, not leaf %0d.",
			status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_NOTABLE],
			status_hits[ST_NOTMAPPED], status_hits[ST_NOTLEAF]);
		if (mismatch_count == 0)
			$display("sv39_page_table_mapper test passed");
		else
			$display("sv39_page_table_mapper test failed");
		$finish;
	end

endmodule
